FILE: rtl/cordic_atan2_degrees_top_assert.svh
// Assertion macros shared by the checker.
`ifndef CORDIC_ATAN2_DEGREES_TOP_ASSERT_SVH
`define CORDIC_ATAN2_DEGREES_TOP_ASSERT_SVH
`define CAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/cad_pkg.sv
package cad_pkg;
	localparam int ITERATIONS = 15;
	localparam int SCALE_Q = 28140;
	localparam int MAG_W = 31;
	localparam int QW = 15;
	localparam int CW = 18;
	localparam int AW = 17;
	localparam int DIV_STEPS = 15;
	localparam int DEPTH = DIV_STEPS + ITERATIONS + 3;
	localparam logic [8:0] HALF_TURN = 9'd180;

	// Degrees = trunc(angle * DEG_NUM / DEG_DEN). The reciprocal below is rounded up
	// and scaled by 2^DEG_SHIFT; it gives the exact floor for every angle magnitude
	// the CORDIC can reach (at most the sum of the arctangent table).
	localparam longint DEG_NUM = 5729578;
	localparam longint DEG_DEN = longint'(SCALE_Q) * 100000;
	localparam int DEG_SHIFT = 47;
	localparam int RECIP_W = 39;
	localparam logic [RECIP_W-1:0] DEG_RECIP = RECIP_W'(
		((longint'(1) << (DEG_SHIFT - 6)) * (DEG_NUM / 2) + DEG_DEN / 128 - 1)
		/ (DEG_DEN / 128));

	typedef struct packed {
		logic       x_neg;
		logic       y_neg;
		logic       y_zero;
		logic       x_zero;
	} flags_t;

	function automatic logic [AW-1:0] atan_entry(input int i);
		logic [AW-1:0] r;
		case (i)
			0: r = 17'd22101;
			1: r = 17'd13047;
			2: r = 17'd6894;
			3: r = 17'd3499;
			4: r = 17'd1756;
			5: r = 17'd879;
			6: r = 17'd440;
			7: r = 17'd220;
			8: r = 17'd110;
			9: r = 17'd55;
			10: r = 17'd27;
			11: r = 17'd14;
			12: r = 17'd7;
			13: r = 17'd3;
			14: r = 17'd2;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

FILE: rtl/cordic_atan2_degrees_top.sv
// Fully pipelined atan2 in whole degrees. One vector word is accepted every
// cycle (busy stays low); its result appears with done high after the registers of
// 1 input stage, 15 division cells, 15 CORDIC cells, a multiply stage
// and a correction stage. The receiver cannot stall; results must be taken
// on the cycle they are shown.
module cordic_atan2_degrees_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic              done,
	output logic signed [8:0] angle_degrees
);
	localparam int N = cad_pkg::DIV_STEPS;
	localparam int M = cad_pkg::ITERATIONS;
	localparam int MW = cad_pkg::MAG_W;
	localparam int QW = cad_pkg::QW;
	localparam int PW = cad_pkg::RECIP_W + 16;

	logic [cad_pkg::DEPTH-1:0] vld_q;
	logic [31:0] ax, ay;
	logic [MW-1:0] axs, ays;

	logic [MW-1:0] rem [0:N];
	logic [MW-1:0] den [0:N];
	logic [QW-1:0] quo [0:N];
	logic [QW-1:0] low_sh [0:N];
	logic swp [0:N];
	cad_pkg::flags_t fd [0:N];

	logic signed [cad_pkg::CW-1:0] cx [0:M];
	logic signed [cad_pkg::CW-1:0] cy [0:M];
	logic signed [cad_pkg::AW-1:0] ca [0:M];
	cad_pkg::flags_t fc [0:M];

	logic [MW+15:0] num_w;
	logic [MW-1:0] small_m, large_m;
	logic sw;
	logic [MW-1:0] rem0_q;
	logic [MW-1:0] den0_q;
	logic [QW-1:0] low_bits_q;
	logic swap0_q;
	cad_pkg::flags_t flg0_q;

	logic [15:0] amag;
	logic [PW-1:0] prod_s1;
	logic aneg_s1;
	cad_pkg::flags_t flg_s1;
	logic [7:0] dmag;
	logic signed [8:0] deg;
	logic signed [8:0] fin;
	logic signed [8:0] res_q;

	assign busy = 1'b0;

	always_comb begin
		ax = x_coord[31] ? (~x_coord + 32'd1) : x_coord;
		ay = y_coord[31] ? (~y_coord + 32'd1) : y_coord;
		axs = ax[31] ? {MW{1'b1}} : ax[MW-1:0];
		ays = ay[31] ? {MW{1'b1}} : ay[MW-1:0];
	end

	always_comb begin
		sw = axs < ays;
		small_m = sw ? axs : ays;
		large_m = sw ? ays : axs;
		num_w = {16'd0, small_m} * (MW+16)'(cad_pkg::SCALE_Q);
	end

	// The product small*Q < large*2^15, so its top part is a valid starting
	// remainder (below large); the low 15 bits are shifted in by the cells.
	always_ff @(posedge clk) begin
		rem0_q <= num_w[MW+QW-1:QW];
		low_bits_q <= num_w[QW-1:0];
		den0_q <= large_m;
		swap0_q <= sw;
		flg0_q <= '{x_neg: x_coord[31], y_neg: y_coord[31], y_zero: (ays == '0),
			x_zero: (axs == '0)};
	end

	assign rem[0] = rem0_q;
	assign den[0] = den0_q;
	assign quo[0] = '0;
	assign low_sh[0] = low_bits_q;
	assign swp[0] = swap0_q;
	assign fd[0] = flg0_q;

	for (genvar g = 0; g < N; g++) begin : g_div
		cad_div_cell u_cell (
			.clk(clk), .rem_in(rem[g]), .den_in(den[g]), .quo_in(quo[g]),
			.low_in(low_sh[g]), .swap_in(swp[g]), .flg_in(fd[g]),
			.rem_q(rem[g+1]), .den_q(den[g+1]), .quo_q(quo[g+1]),
			.low_q(low_sh[g+1]), .swap_q(swp[g+1]), .flg_q(fd[g+1])
		);
	end

	assign cx[0] = swp[N] ? cad_pkg::CW'(quo[N]) : cad_pkg::CW'(cad_pkg::SCALE_Q);
	assign cy[0] = swp[N] ? cad_pkg::CW'(cad_pkg::SCALE_Q) : cad_pkg::CW'(quo[N]);
	assign ca[0] = '0;
	assign fc[0] = fd[N];

	for (genvar k = 0; k < M; k++) begin : g_cordic
		cad_cordic_cell u_cell (
			.clk(clk), .stage_idx(4'(k)), .x_in(cx[k]), .y_in(cy[k]), .a_in(ca[k]),
			.flg_in(fc[k]), .x_q(cx[k+1]), .y_q(cy[k+1]), .a_q(ca[k+1]),
			.flg_q(fc[k+1])
		);
	end

	// Degrees = trunc(angle * 57.29578 / Q): the angle magnitude is multiplied
	// by a rounded-up reciprocal and the sign is put back afterwards.
	assign amag = ca[M][cad_pkg::AW-1] ? 16'(-ca[M]) : 16'(ca[M]);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(amag) * PW'(cad_pkg::DEG_RECIP);
		aneg_s1 <= ca[M][cad_pkg::AW-1];
		flg_s1 <= fc[M];
	end

	always_comb begin
		dmag = prod_s1[cad_pkg::DEG_SHIFT+7:cad_pkg::DEG_SHIFT];
		deg = aneg_s1 ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
		if (flg_s1.y_zero) fin = flg_s1.x_neg ? $signed(cad_pkg::HALF_TURN) : 9'sd0;
		else begin
			fin = (flg_s1.x_neg || flg_s1.x_zero) ? $signed(cad_pkg::HALF_TURN) - deg : deg;
			if (flg_s1.y_neg) fin = -fin;
		end
	end

	always_ff @(posedge clk) res_q <= fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[cad_pkg::DEPTH-2:0], start};
	end

	assign done = vld_q[cad_pkg::DEPTH-1];
	assign angle_degrees = res_q;
endmodule

FILE: rtl/cad_div_cell.sv
// One restoring division step: one quotient bit of floor(num * Q / den).
module cad_div_cell (
	input  logic                          clk,
	input  logic [cad_pkg::MAG_W-1:0]     rem_in,
	input  logic [cad_pkg::MAG_W-1:0]     den_in,
	input  logic [cad_pkg::QW-1:0]        quo_in,
	input  logic [cad_pkg::QW-1:0]        low_in,
	input  logic                          swap_in,
	input  cad_pkg::flags_t               flg_in,
	output logic [cad_pkg::MAG_W-1:0]     rem_q,
	output logic [cad_pkg::MAG_W-1:0]     den_q,
	output logic [cad_pkg::QW-1:0]        quo_q,
	output logic [cad_pkg::QW-1:0]        low_q,
	output logic                          swap_q,
	output cad_pkg::flags_t               flg_q
);
	logic [cad_pkg::MAG_W:0] dbl;
	logic [cad_pkg::MAG_W:0] diff;
	logic                    bit_ok;

	// The next dividend bit comes from the top of the remaining low bits.
	always_comb begin
		dbl = {rem_in, low_in[cad_pkg::QW-1]};
		diff = dbl - {1'b0, den_in};
		bit_ok = !diff[cad_pkg::MAG_W];
	end

	always_ff @(posedge clk) begin
		rem_q <= bit_ok ? diff[cad_pkg::MAG_W-1:0] : dbl[cad_pkg::MAG_W-1:0];
		den_q <= den_in;
		quo_q <= {quo_in[cad_pkg::QW-2:0], bit_ok};
		low_q <= {low_in[cad_pkg::QW-2:0], 1'b0};
		swap_q <= swap_in;
		flg_q <= flg_in;
	end
endmodule

FILE: rtl/cad_cordic_cell.sv
// One CORDIC vectoring step; stage_idx is tied to a constant by the parent.
module cad_cordic_cell (
	input  logic                         clk,
	input  logic [3:0]                   stage_idx,
	input  logic signed [cad_pkg::CW-1:0] x_in,
	input  logic signed [cad_pkg::CW-1:0] y_in,
	input  logic signed [cad_pkg::AW-1:0] a_in,
	input  cad_pkg::flags_t              flg_in,
	output logic signed [cad_pkg::CW-1:0] x_q,
	output logic signed [cad_pkg::CW-1:0] y_q,
	output logic signed [cad_pkg::AW-1:0] a_q,
	output cad_pkg::flags_t              flg_q
);
	logic signed [cad_pkg::AW-1:0] atan_v;
	logic signed [cad_pkg::CW-1:0] xs;
	logic signed [cad_pkg::CW-1:0] ys;

	always_comb begin
		atan_v = cad_pkg::atan_entry(int'(stage_idx));
		xs = x_in >>> stage_idx;
		ys = y_in >>> stage_idx;
	end

	always_ff @(posedge clk) begin
		if (y_in < 0) begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			a_q <= a_in - atan_v;
		end else begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			a_q <= a_in + atan_v;
		end
		flg_q <= flg_in;
	end
endmodule

FILE: rtl/cad_checker.sv
`include "cordic_atan2_degrees_top_assert.svh"
module cad_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [8:0] angle_degrees
);
	`CAD_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
	`CAD_ASSERT_IMPL(a_range, clk, arst_n, done, (angle_degrees <= 9'sd180) && (angle_degrees >= -9'sd180), "angle out of range")
	`CAD_ASSERT_IMPL(a_latency, clk, arst_n, done, $past(start, 33), "done without start")
endmodule

bind cordic_atan2_degrees_top cad_checker u_cad_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.angle_degrees(angle_degrees)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} vec_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic done;
	logic signed [8:0] angle_degrees;

	vec_t pending_words[$];
	logic signed [8:0] expected_angles[$];
	int err_count = 0;
	int gap_left = 0;

	cordic_atan2_degrees_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.done(done),
		.angle_degrees(angle_degrees)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] abs_sat(logic [31:0] raw);
		logic [31:0] m;
		if (!raw[31]) return raw;
		m = ~raw + 32'd1;
		return (m == 32'h8000_0000) ? 32'h7FFF_FFFF : m;
	endfunction

	function automatic logic signed [8:0] atan2_deg(logic signed [31:0] x, logic signed [31:0] y);
		logic [31:0] ax;
		logic [31:0] ay;
		longint xq;
		longint yq;
		longint xs;
		longint ys;
		longint ang;
		longint deg;
		longint atab[15];
		atab = '{22101, 13047, 6894, 3499, 1756, 879, 440, 220, 110, 55, 27, 14, 7, 3, 2};
		ax = abs_sat(x);
		ay = abs_sat(y);
		if (ay == 0) return x[31] ? 9'sd180 : 9'sd0;
		if (ax < ay) begin
			xq = longint'((64'(ax) * 28140) / 64'(ay));
			yq = 28140;
		end else begin
			yq = longint'((64'(ay) * 28140) / 64'(ax));
			xq = 28140;
		end
		ang = 0;
		for (int i = 0; i < 15; i++) begin
			xs = xq >>> i;
			ys = yq >>> i;
			if (yq < 0) begin
				xq -= ys;
				yq += xs;
				ang -= atab[i];
			end else begin
				xq += ys;
				yq -= xs;
				ang += atab[i];
			end
		end
		// Signed division truncates toward zero, as the angle conversion requires.
		deg = (ang * 5729578) / (longint'(28140) * 100000);
		if (x[31] || ax == 0) deg = 180 - deg;
		if (y[31]) deg = -deg;
		return deg[8:0];
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		err_count++;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 40) - 20;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			2: return $urandom_range(0, 200000) - 100000;
			3: return 32'($urandom) >>> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Driver: inputs change on the falling edge; a word is taken when start is high and busy low.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			x_coord <= '0;
			y_coord <= '0;
		end else if (start && busy) begin
			// hold the word until it is taken
		end else begin
			if (start) begin
				expected_angles.push_back(atan2_deg(x_coord, y_coord));
				void'(pending_words.pop_front());
			end
			if (pending_words.size() > 0 && gap_left == 0) begin
				start <= 1'b1;
				x_coord <= pending_words[0].x;
				y_coord <= pending_words[0].y;
				gap_left = rand_gap();
			end else begin
				start <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
	end

	// Monitor: results are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", angle_degrees));
			end else if (angle_degrees !== expected_angles[0]) begin
				report_mismatch($sformatf("angle_degrees got %0d, want %0d",
					angle_degrees, expected_angles[0]));
				void'(expected_angles.pop_front());
			end else begin
				void'(expected_angles.pop_front());
			end
		end
	end

	initial begin
		vec_t v;
		logic signed [31:0] edge_vals[7];
		edge_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1, 32'sh8000_0001, 100};
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed words: extremes, zero y, zero x, equal magnitudes, all quadrants.
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				v.x = edge_vals[i];
				v.y = edge_vals[(j + 2) % 7];
				pending_words.push_back(v);
			end
		end
		v.x = -7; v.y = 7; pending_words.push_back(v);
		v.x = 32'sh8000_0000; v.y = 32'sh8000_0001; pending_words.push_back(v);
		for (int n = 0; n < 1900; n++) begin
			v.x = rand_coord();
			v.y = rand_coord();
			if ($urandom_range(0, 15) == 0) v.y = v.x;
			if ($urandom_range(0, 15) == 0) v.y = 0;
			if ($urandom_range(0, 15) == 0) v.x = 0;
			pending_words.push_back(v);
		end
		wait (pending_words.size() == 0);
		@(negedge clk);
		@(negedge clk);
		wait (expected_angles.size() == 0);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/cad_pkg.sv
rtl/cad_div_cell.sv
rtl/cad_cordic_cell.sv
rtl/cordic_atan2_degrees_top.sv
rtl/cad_checker.sv
bench/tb_top.sv
